// ===== rtl/core/cmbc_pkg.sv =====
// Shared types and constants for the combinatorics count block.
`default_nettype none

package cmbc_pkg;

    // Input field width (n and r).
    localparam int N_W      = 6;
    // Width of a saturated count.
    localparam int CNT_W    = 63;
    // Widest multiplier factor: m - j + 1 with m up to n + r - 1.
    localparam int FAC_W    = N_W + 1;
    // Product of a count and a factor.
    localparam int PROD_W   = CNT_W + FAC_W;
    // Divider retires this many quotient bits per cycle.
    localparam int DIG_BITS = 4;
    localparam int DIV_STEPS = (PROD_W + DIG_BITS - 1) / DIG_BITS;
    localparam int WORK_W   = DIV_STEPS * DIG_BITS;
    localparam int STEP_W   = $clog2(DIV_STEPS);
    localparam int NUM_CNT  = 4;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [N_W-1:0]    divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_TEST,
        ST_MUL,
        ST_DSTART,
        ST_DIV,
        ST_UPD,
        ST_DONE
    } state_t;

    // Order matches the bits of the overflow flags.
    typedef enum logic [1:0] {
        PH_PERM,
        PH_POW,
        PH_COMB,
        PH_HCOMB
    } phase_t;

endpackage

`default_nettype wire

// ===== rtl/core/cmbc_div.sv =====
// Iterative radix-16 divider of a product by a small divisor.
`default_nettype none

module cmbc_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cmbc_pkg::div_req_t req,
    output cmbc_pkg::div_rsp_t      rsp
);
    import cmbc_pkg::*;

    // Dividend bits leave at the top while quotient bits enter at the bottom.
    logic [WORK_W-1:0] work_reg, work_next;
    logic [N_W-1:0]    rem_reg, rem_next;
    logic [N_W-1:0]    divisor_reg, divisor_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    always_comb
    begin
        logic [N_W:0]      trial;
        logic [N_W-1:0]    r;
        logic [WORK_W-1:0] w;

        work_next    = work_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        step_next    = step_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        r            = rem_reg;
        w            = work_reg;
        trial        = '0;

        if (req.start)
        begin
            work_next    = {{(WORK_W-PROD_W){1'b0}}, req.dividend};
            rem_next     = '0;
            divisor_next = req.divisor;
            step_next    = '0;
            busy_next    = 1'b1;
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < DIG_BITS; i++)
            begin
                trial = {r, w[WORK_W-1]};
                w     = {w[WORK_W-2:0], 1'b0};
                if (trial >= {1'b0, divisor_reg})
                begin
                    trial = trial - {1'b0, divisor_reg};
                    w[0]  = 1'b1;
                end
                r = trial[N_W-1:0];
            end
            work_next = w;
            rem_next  = r;
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg    <= work_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = work_reg[PROD_W-1:0];

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

    a_step_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (step_reg < STEP_W'(DIV_STEPS)))
        else $error("divider step count past the last digit");

endmodule

`default_nettype wire

// ===== rtl/core/combinatorics_counts.sv =====
// Top level: exact nPr, n^r, nCr and C(n+r-1, r) with saturation at 2^63-1.
`default_nettype none

// Takes n and r and returns the four counts nPr, n^r, nCr and nHr = C(n+r-1, r),
// each exact or saturated at 2^63-1 with its overflow bit set; n = 0 or n < r
// returns out_of_range with all counts and flags zero. One item is worked at a
// time: a single 63x7 multiplier runs the products, and for the two binomials
// each multiply is followed by an exact division by the step index on a
// radix-16 divider. The nCr loop runs up to min(r, n-r) and the nHr loop up to
// min(r, n-1); a count that saturates stops its loop early. A finished result
// waits in the output register while the next item is accepted.
module combinatorics_counts (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [cmbc_pkg::N_W-1:0]   n_items,
    input  wire logic [cmbc_pkg::N_W-1:0]   r_chosen,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic                            out_of_range,
    output logic [cmbc_pkg::CNT_W-1:0]      permutations,
    output logic [cmbc_pkg::CNT_W-1:0]      repeated_permutations,
    output logic [cmbc_pkg::CNT_W-1:0]      combinations,
    output logic [cmbc_pkg::CNT_W-1:0]      repeated_combinations,
    output logic [cmbc_pkg::NUM_CNT-1:0]    overflow_flags
);
    import cmbc_pkg::*;

    state_t              state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic [N_W-1:0]      n_reg, n_next;
    logic [N_W-1:0]      r_reg, r_next;
    logic [FAC_W-1:0]    m_reg, m_next;
    logic [N_W-1:0]      limit_reg, limit_next;
    logic [N_W-1:0]      cnt_reg, cnt_next;
    logic [CNT_W-1:0]    acc_reg, acc_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [CNT_W-1:0]    res_reg [NUM_CNT];
    logic [CNT_W-1:0]    res_next [NUM_CNT];
    logic [NUM_CNT-1:0]  flags_reg, flags_next;
    logic                oor_reg, oor_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_load;

    logic                oor_o_reg;
    logic [CNT_W-1:0]    perm_o_reg, pow_o_reg, comb_o_reg, hcomb_o_reg;
    logic [NUM_CNT-1:0]  flags_o_reg;

    logic [FAC_W-1:0]    factor;
    logic [PROD_W-1:0]   mul_out;
    logic [PROD_W-1:0]   upd_val;
    logic                binom_phase;
    logic [N_W-1:0]      n_minus_r, n_minus_1;

    div_req_t            div_req;
    div_rsp_t            div_rsp;

    cmbc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign binom_phase = (phase_reg == PH_COMB) || (phase_reg == PH_HCOMB);
    assign n_minus_r   = n_reg - r_reg;
    assign n_minus_1   = n_reg - N_W'(1);

    // Factor for the current step: n - i, n, or m - j + 1 with j = cnt + 1.
    always_comb
    begin
        case (phase_reg)
            PH_PERM: factor = {1'b0, n_reg} - {1'b0, cnt_reg};
            PH_POW:  factor = {1'b0, n_reg};
            default: factor = m_reg - {1'b0, cnt_reg};
        endcase
    end

    assign mul_out = acc_reg * factor;
    assign upd_val = binom_phase ? div_rsp.quotient : prod_reg;

    assign div_req.start    = (state_reg == ST_DSTART);
    assign div_req.dividend = prod_reg;
    assign div_req.divisor  = cnt_reg + N_W'(1);

    always_comb
    begin
        logic             fin;
        logic [CNT_W-1:0] fin_val;
        logic             fin_ovf;

        state_next     = state_reg;
        phase_next     = phase_reg;
        n_next         = n_reg;
        r_next         = r_reg;
        m_next         = m_reg;
        limit_next     = limit_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        res_next       = res_reg;
        flags_next     = flags_reg;
        oor_next       = oor_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_load       = 1'b0;
        fin            = 1'b0;
        fin_val        = acc_reg;
        fin_ovf        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    n_next     = n_items;
                    r_next     = r_chosen;
                    flags_next = '0;
                    phase_next = PH_PERM;
                    if ((n_items == '0) || (n_items < r_chosen))
                    begin
                        oor_next = 1'b1;
                        for (int i = 0; i < NUM_CNT; i++)
                        begin
                            res_next[i] = '0;
                        end
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        oor_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                end
            end

            ST_LOAD:
            begin
                acc_next = CNT_W'(1);
                cnt_next = '0;
                m_next   = (phase_reg == PH_HCOMB) ?
                           ({1'b0, n_reg} + {1'b0, r_reg} - FAC_W'(1)) : {1'b0, n_reg};
                // Binomials run only up to the smaller side so every step grows.
                case (phase_reg)
                    PH_COMB:  limit_next = (r_reg < n_minus_r) ? r_reg : n_minus_r;
                    PH_HCOMB: limit_next = (r_reg < n_minus_1) ? r_reg : n_minus_1;
                    default:  limit_next = r_reg;
                endcase
                state_next = ST_TEST;
            end

            ST_TEST:
            begin
                if (cnt_reg == limit_reg)
                begin
                    fin = 1'b1;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end

            ST_MUL:
            begin
                prod_next  = mul_out;
                state_next = binom_phase ? ST_DSTART : ST_UPD;
            end

            ST_DSTART:
            begin
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_UPD;
                end
            end

            ST_UPD:
            begin
                if (upd_val[PROD_W-1:CNT_W] != '0)
                begin
                    fin     = 1'b1;
                    fin_val = CNT_MAX;
                    fin_ovf = 1'b1;
                end
                else
                begin
                    acc_next   = upd_val[CNT_W-1:0];
                    cnt_next   = cnt_reg + N_W'(1);
                    state_next = ST_TEST;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Store the finished count and move on to the next one, or to the output after the last.
        if (fin)
        begin
            res_next[phase_reg]   = fin_val;
            flags_next[phase_reg] = fin_ovf;
            if (phase_reg == PH_HCOMB)
            begin
                state_next = ST_DONE;
            end
            else
            begin
                phase_next = phase_t'(phase_reg + 2'd1);
                state_next = ST_LOAD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_PERM;
            cnt_reg       <= '0;
            limit_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        r_reg     <= r_next;
        m_reg     <= m_next;
        acc_reg   <= acc_next;
        prod_reg  <= prod_next;
        res_reg   <= res_next;
        flags_reg <= flags_next;
        oor_reg   <= oor_next;
        if (out_load)
        begin
            oor_o_reg   <= oor_reg;
            perm_o_reg  <= res_reg[PH_PERM];
            pow_o_reg   <= res_reg[PH_POW];
            comb_o_reg  <= res_reg[PH_COMB];
            hcomb_o_reg <= res_reg[PH_HCOMB];
            flags_o_reg <= flags_reg;
        end
    end

    assign in_stall              = (state_reg != ST_IDLE);
    assign out_valid             = out_valid_reg;
    assign out_of_range          = oor_o_reg;
    assign permutations          = perm_o_reg;
    assign repeated_permutations = pow_o_reg;
    assign combinations          = comb_o_reg;
    assign repeated_combinations = hcomb_o_reg;
    assign overflow_flags        = flags_o_reg;

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the wait state");

    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (cnt_reg < limit_reg))
        else $error("multiply step past the loop limit");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_of_range) |->
            (overflow_flags == '0 && permutations == '0 && combinations == '0))
        else $error("out-of-range result carries nonzero counts");

    a_comb_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && overflow_flags[PH_COMB]) |-> (combinations == CNT_MAX))
        else $error("combination overflow without saturation");

endmodule

`default_nettype wire

// ===== bench/combinatorics_counts_tb.sv =====
// Testbench for combinatorics_counts: directed table plus random n/r checked against a predictor.
`timescale 1ns / 100ps

module combinatorics_counts_tb;
    import cmbc_pkg::*;

    localparam int N_DIR       = 21;
    localparam int RAND_ITEMS  = 1000;
    localparam int DRAIN_LIMIT = 20000;
    localparam int TAIL_CYCLES = 2500;
    localparam int HOLD_CYCLES = 4000;

    localparam logic [63:0] MAX64  = {1'b0, CNT_MAX};
    localparam logic [63:0] OVER64 = 64'h8000_0000_0000_0000;

    localparam logic [NUM_CNT-1:0] FLG_PERM  = NUM_CNT'(1 << PH_PERM);
    localparam logic [NUM_CNT-1:0] FLG_POW   = NUM_CNT'(1 << PH_POW);
    localparam logic [NUM_CNT-1:0] FLG_HCOMB = NUM_CNT'(1 << PH_HCOMB);

    typedef struct packed {
        logic               oor;
        logic [CNT_W-1:0]   perm;
        logic [CNT_W-1:0]   rperm;
        logic [CNT_W-1:0]   comb;
        logic [CNT_W-1:0]   rcomb;
        logic [NUM_CNT-1:0] flags;
    } counts_t;

    typedef struct packed {
        logic [N_W-1:0] n;
        logic [N_W-1:0] r;
        logic           typed;
        counts_t        want;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [N_W-1:0]       n_items;
    logic [N_W-1:0]       r_chosen;
    logic                 out_valid;
    logic                 out_stall;
    logic                 out_of_range;
    logic [CNT_W-1:0]     permutations;
    logic [CNT_W-1:0]     repeated_permutations;
    logic [CNT_W-1:0]     combinations;
    logic [CNT_W-1:0]     repeated_combinations;
    logic [NUM_CNT-1:0]   overflow_flags;

    counts_t  pending_counts [$];
    dir_row_t dir_tab [0:N_DIR-1];
    int       err_count;
    int       send_idle_pct;
    int       recv_idle_pct;
    logic     hold_start;
    logic     hold_off;

    combinatorics_counts dut (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .in_valid              (in_valid),
        .in_stall              (in_stall),
        .n_items               (n_items),
        .r_chosen              (r_chosen),
        .out_valid             (out_valid),
        .out_stall             (out_stall),
        .out_of_range          (out_of_range),
        .permutations          (permutations),
        .repeated_permutations (repeated_permutations),
        .combinations          (combinations),
        .repeated_combinations (repeated_combinations),
        .overflow_flags        (overflow_flags)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // C(m, k) by Pascal rows with entries clamped just above the count range
    function automatic logic binom_sat(input int m, input int k, output logic [CNT_W-1:0] val);
        logic [63:0] row [0:63];
        logic [64:0] sum;
        int          i;
        int          j;
        int          top;
        for (i = 0; i < 64; i++)
            row[i] = '0;
        row[0] = 64'd1;
        for (i = 1; i <= m; i++)
        begin
            top = (i < k) ? i : k;
            for (j = top; j >= 1; j--)
            begin
                sum = {1'b0, row[j]} + {1'b0, row[j-1]};
                row[j] = (sum > {1'b0, OVER64}) ? OVER64 : sum[63:0];
            end
        end
        if (row[k] > MAX64)
        begin
            val = CNT_MAX;
            return 1'b1;
        end
        val = row[k][CNT_W-1:0];
        return 1'b0;
    endfunction

    function automatic counts_t predict_counts(input logic [N_W-1:0] n, input logic [N_W-1:0] r);
        counts_t     c;
        logic [63:0] acc;
        int          k;
        c = '0;
        if (n == 0 || n < r)
        begin
            c.oor = 1'b1;
            return c;
        end
        acc = 64'd1;
        for (k = int'(n) - int'(r) + 1; k <= int'(n); k++)
        begin
            if (acc > MAX64 / 64'(k))
            begin
                acc = MAX64;
                c.flags[PH_PERM] = 1'b1;
                break;
            end
            acc = acc * 64'(k);
        end
        c.perm = acc[CNT_W-1:0];
        acc = 64'd1;
        for (k = 0; k < int'(r); k++)
        begin
            if (acc > MAX64 / 64'(n))
            begin
                acc = MAX64;
                c.flags[PH_POW] = 1'b1;
                break;
            end
            acc = acc * 64'(n);
        end
        c.rperm = acc[CNT_W-1:0];
        c.flags[PH_COMB]  = binom_sat(int'(n), int'(r), c.comb);
        c.flags[PH_HCOMB] = binom_sat(int'(n) + int'(r) - 1, int'(r), c.rcomb);
        return c;
    endfunction

    function automatic dir_row_t dir_row(input logic [N_W-1:0] n, input logic [N_W-1:0] r,
                                         input logic typed, input counts_t want);
        dir_row_t row;
        row.n     = n;
        row.r     = r;
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(input logic [N_W-1:0] n, input logic [N_W-1:0] r, input counts_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        n_items  = n;
        r_chosen = r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_counts.push_back(want);
        @(negedge clk);
    endtask

    always @(negedge clk)
        out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);

    initial
    begin
        hold_off = 1'b0;
        wait (hold_start);
        @(negedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES)
            @(negedge clk);
        hold_off = 1'b0;
    end

    always @(posedge clk)
    begin
        counts_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_counts.size() == 0)
            begin
                $error("result transfer with no expectation pending");
                err_count++;
            end
            else
            begin
                want = pending_counts.pop_front();
                if (out_of_range !== want.oor)
                begin
                    $error("out_of_range: expected %0d, got %0d", want.oor, out_of_range);
                    err_count++;
                end
                if (permutations !== want.perm)
                begin
                    $error("permutations: expected %0d, got %0d", want.perm, permutations);
                    err_count++;
                end
                if (repeated_permutations !== want.rperm)
                begin
                    $error("repeated_permutations: expected %0d, got %0d",
                           want.rperm, repeated_permutations);
                    err_count++;
                end
                if (combinations !== want.comb)
                begin
                    $error("combinations: expected %0d, got %0d", want.comb, combinations);
                    err_count++;
                end
                if (repeated_combinations !== want.rcomb)
                begin
                    $error("repeated_combinations: expected %0d, got %0d",
                           want.rcomb, repeated_combinations);
                    err_count++;
                end
                if (overflow_flags !== want.flags)
                begin
                    $error("overflow_flags: expected %b, got %b", want.flags, overflow_flags);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        #200_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int             i;
        int             kind;
        int             guard;
        logic [N_W-1:0] n;
        logic [N_W-1:0] r;
        counts_t        want;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        n_items       = '0;
        r_chosen      = '0;
        hold_start    = 1'b0;
        err_count     = 0;
        send_idle_pct = 17;
        recv_idle_pct = 74;

        dir_tab[0]  = dir_row(6'd0,  6'd0,  1'b1, '{1'b1, '0, '0, '0, '0, '0});
        dir_tab[1]  = dir_row(6'd0,  6'd63, 1'b1, '{1'b1, '0, '0, '0, '0, '0});
        dir_tab[2]  = dir_row(6'd5,  6'd6,  1'b1, '{1'b1, '0, '0, '0, '0, '0});
        dir_tab[3]  = dir_row(6'd62, 6'd63, 1'b1, '{1'b1, '0, '0, '0, '0, '0});
        dir_tab[4]  = dir_row(6'd1,  6'd0,  1'b1, '{1'b0, 63'd1, 63'd1, 63'd1, 63'd1, '0});
        dir_tab[5]  = dir_row(6'd63, 6'd0,  1'b1, '{1'b0, 63'd1, 63'd1, 63'd1, 63'd1, '0});
        dir_tab[6]  = dir_row(6'd1,  6'd1,  1'b1, '{1'b0, 63'd1, 63'd1, 63'd1, 63'd1, '0});
        dir_tab[7]  = dir_row(6'd63, 6'd1,  1'b1, '{1'b0, 63'd63, 63'd63, 63'd63, 63'd63, '0});
        dir_tab[8]  = dir_row(6'd63, 6'd63, 1'b1, '{1'b0, CNT_MAX, CNT_MAX, 63'd1, CNT_MAX,
                                                   FLG_PERM | FLG_POW | FLG_HCOMB});
        // Boundaries of 20!, 16^16 and the central binomials near 2^63
        dir_tab[9]  = dir_row(6'd20, 6'd20, 1'b0, '0);
        dir_tab[10] = dir_row(6'd21, 6'd21, 1'b0, '0);
        dir_tab[11] = dir_row(6'd15, 6'd15, 1'b0, '0);
        dir_tab[12] = dir_row(6'd16, 6'd16, 1'b0, '0);
        dir_tab[13] = dir_row(6'd62, 6'd31, 1'b0, '0);
        dir_tab[14] = dir_row(6'd34, 6'd33, 1'b0, '0);
        dir_tab[15] = dir_row(6'd35, 6'd33, 1'b0, '0);
        dir_tab[16] = dir_row(6'd42, 6'd21, 1'b0, '0);
        dir_tab[17] = dir_row(6'd21, 6'd10, 1'b0, '0);
        dir_tab[18] = dir_row(6'd2,  6'd1,  1'b0, '0);
        dir_tab[19] = dir_row(6'd5,  6'd3,  1'b0, '0);
        dir_tab[20] = dir_row(6'd10, 6'd5,  1'b0, '0);

        repeat (7)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (i = 0; i < N_DIR; i++)
        begin
            want = dir_tab[i].typed ? dir_tab[i].want
                                    : predict_counts(dir_tab[i].n, dir_tab[i].r);
            send_item(dir_tab[i].n, dir_tab[i].r, want);
        end

        for (i = 0; i < RAND_ITEMS; i++)
        begin
            if (i == RAND_ITEMS / 3)
            begin
                send_idle_pct = 74;
                recv_idle_pct = 17;
            end
            if (i == 2 * RAND_ITEMS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // Stall the output for a long stretch while transfers keep coming
            if (i == 2 * RAND_ITEMS / 3 + 10)
                hold_start = 1'b1;
            kind = $urandom_range(99);
            if (kind < 60)
            begin
                n = N_W'($urandom_range(20, 1));
                r = N_W'($urandom_range(n, 0));
            end
            else if (kind < 75)
            begin
                n = N_W'($urandom_range(63, 1));
                r = N_W'($urandom_range(n, 0));
            end
            else if (kind < 90)
            begin
                n = N_W'($urandom);
                r = N_W'($urandom);
            end
            else
            begin
                n = N_W'($urandom_range(62, 0));
                r = N_W'($urandom_range(63, n + 1));
            end
            send_item(n, r, predict_counts(n, r));
        end
        in_valid = 1'b0;

        guard = 0;
        while (pending_counts.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        if (pending_counts.size() != 0)
        begin
            $error("%0d results never arrived", pending_counts.size());
            err_count++;
        end
        repeat (TAIL_CYCLES)
            @(posedge clk);

        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
